/* design/tmaf_pkg.sv */
// Shared types and constants of the trimmed-mean agreement filter.
package tmaf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 8;
    // Widest trimmed group total: sixteen full-scale samples.
    localparam int TOTAL_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'hFFF;
    localparam logic [SAMPLE_W-1:0] RANGE_RESET = 12'd50;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               second_grp;
        logic [CHAN_W-1:0]  channel;
    } group_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* design/tmaf_in_if.sv */
// Sample input channel: valid/ready with sample and channel tag.
interface tmaf_in_if;
    logic                          valid;
    logic                          ready;
    logic [tmaf_pkg::SAMPLE_W-1:0] sample;
    logic [tmaf_pkg::CHAN_W-1:0]   channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

/* design/tmaf_out_if.sv */
// Result output channel: valid/ready with filtered value, agree flag and channel tag.
interface tmaf_out_if;
    logic                          valid;
    logic                          ready;
    logic [tmaf_pkg::SAMPLE_W-1:0] value;
    logic                          agreed;
    logic [tmaf_pkg::CHAN_W-1:0]   result_channel;

    modport source (output valid, output value, output agreed, output result_channel,
                    input ready);
    modport sink   (input valid, input value, input agreed, input result_channel,
                     output ready);
endinterface

/* design/tmaf_front.sv */
// Front end: running sum, min and max per group; emits each total less min+max if TRIM.
module tmaf_front #(
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int DROP_EACH_END     = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    tmaf_in_if.sink                 samples,
    input  tmaf_pkg::queue_status_t q_status,
    output logic                    push,
    output tmaf_pkg::group_rec_t    rec
);

    localparam int CNT_W = $clog2(SAMPLES_PER_GROUP);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES_PER_GROUP - 1);
    localparam bit TRIM = (DROP_EACH_END != 0);

    logic [tmaf_pkg::TOTAL_W-1:0]  sum_reg;
    logic [tmaf_pkg::SAMPLE_W-1:0] min_reg;
    logic [tmaf_pkg::SAMPLE_W-1:0] max_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          second_reg;

    logic                          grp_last;
    logic                          accept;
    logic [tmaf_pkg::SAMPLE_W-1:0] min_next;
    logic [tmaf_pkg::SAMPLE_W-1:0] max_next;
    logic [tmaf_pkg::TOTAL_W-1:0]  sum_next;
    logic [tmaf_pkg::TOTAL_W-1:0]  trim_amt;

    assign grp_last      = (count_reg == LAST_IDX);
    // Stall only when this sample closes a group and the queue has no room.
    assign samples.ready = !(grp_last && q_status.full);
    assign accept        = samples.valid && samples.ready;

    assign min_next = (samples.sample < min_reg) ? samples.sample : min_reg;
    assign max_next = (samples.sample > max_reg) ? samples.sample : max_reg;
    assign sum_next = sum_reg + tmaf_pkg::TOTAL_W'(samples.sample);
    assign trim_amt = TRIM ? (tmaf_pkg::TOTAL_W'(min_next) + tmaf_pkg::TOTAL_W'(max_next))
                           : '0;

    assign push           = accept && grp_last;
    assign rec.total      = sum_next - trim_amt;
    assign rec.second_grp = second_reg;
    assign rec.channel    = samples.channel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            min_reg    <= tmaf_pkg::SAMPLE_MAX;
            max_reg    <= '0;
            count_reg  <= '0;
            second_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (grp_last)
            begin
                sum_reg    <= '0;
                min_reg    <= tmaf_pkg::SAMPLE_MAX;
                max_reg    <= '0;
                count_reg  <= '0;
                second_reg <= !second_reg;
            end
            else
            begin
                sum_reg   <= sum_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

endmodule

/* design/tmaf_queue.sv */
// Short queue of closed-group records between front and back.
module tmaf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tmaf_pkg::group_rec_t    wr_rec,
    input  logic                    pop,
    output tmaf_pkg::group_rec_t    rd_rec,
    output tmaf_pkg::queue_status_t status
);

    localparam int DEPTH = tmaf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tmaf_pkg::group_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign rd_rec       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/tmaf_back.sv */
// Back end: divide group totals into means, hold the first, compare and emit the result.
module tmaf_back #(
    parameter int KEEP = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tmaf_pkg::SAMPLE_W-1:0] agree_range,
    input  tmaf_pkg::queue_status_t       q_status,
    input  tmaf_pkg::group_rec_t          q_rec,
    output logic                          pop,
    tmaf_out_if.source                    results
);

    localparam int TW     = tmaf_pkg::TOTAL_W;
    localparam int SW     = tmaf_pkg::SAMPLE_W;
    localparam int RCP_W  = TW + 1;
    localparam int PROD_W = TW + RCP_W;
    // floor(2^TW / KEEP): the estimate is the true quotient or one short.
    localparam logic [RCP_W-1:0] RECIP  = RCP_W'((2 ** TW) / KEEP);
    localparam logic [TW-1:0]    KEEP_V = TW'(KEEP);

    logic                         adv;
    logic [PROD_W-1:0]            prod;

    logic                         a_valid_reg;
    logic [TW-1:0]                a_total_reg;
    logic [TW-1:0]                a_quot_reg;
    logic                         a_second_reg;
    logic [tmaf_pkg::CHAN_W-1:0]  a_chan_reg;

    logic [TW-1:0]                rem;
    logic [TW-1:0]                quot_fix;

    logic                         b_valid_reg;
    logic [SW-1:0]                b_mean_reg;
    logic                         b_second_reg;
    logic [tmaf_pkg::CHAN_W-1:0]  b_chan_reg;

    logic [SW-1:0]                first_mean_reg;
    logic [SW-1:0]                diff;
    logic [SW:0]                  pair_sum;
    logic                         ok;

    logic                         out_valid_reg;
    logic [SW-1:0]                out_value_reg;
    logic                         out_agreed_reg;
    logic [tmaf_pkg::CHAN_W-1:0]  out_chan_reg;

    // Whole pipeline holds while a result waits on the output register.
    assign adv = !out_valid_reg || results.ready;
    assign pop = adv && !q_status.empty;

    assign prod     = PROD_W'(q_rec.total) * PROD_W'(RECIP);
    assign rem      = a_total_reg - TW'(a_quot_reg * KEEP_V);
    assign quot_fix = (rem >= KEEP_V) ? a_quot_reg + TW'(1) : a_quot_reg;

    assign diff     = (b_mean_reg >= first_mean_reg) ? b_mean_reg - first_mean_reg
                                                     : first_mean_reg - b_mean_reg;
    assign ok       = (diff < agree_range);
    assign pair_sum = {1'b0, first_mean_reg} + {1'b0, b_mean_reg};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_total_reg  <= q_rec.total;
            a_quot_reg   <= prod[TW +: TW];
            a_second_reg <= q_rec.second_grp;
            a_chan_reg   <= q_rec.channel;
        end
        if (adv && a_valid_reg)
        begin
            b_mean_reg   <= quot_fix[SW-1:0];
            b_second_reg <= a_second_reg;
            b_chan_reg   <= a_chan_reg;
        end
        if (adv && b_valid_reg && b_second_reg)
        begin
            out_value_reg  <= ok ? pair_sum[SW:1] : '0;
            out_agreed_reg <= ok;
            out_chan_reg   <= b_chan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_mean_reg <= '0;
        end
        else if (adv)
        begin
            a_valid_reg   <= !q_status.empty;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg && b_second_reg;
            if (b_valid_reg && !b_second_reg)
            begin
                first_mean_reg <= b_mean_reg;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.value          = out_value_reg;
    assign results.agreed         = out_agreed_reg;
    assign results.result_channel = out_chan_reg;

endmodule

/* design/touch_trimmed_mean_agree_filter.sv */
// Top level of the touch trimmed-mean filter with double-read agreement check.
//
//  Channel   Dir   Fields                             Transfer when
//  samples   in    sample[11:0], channel[7:0]         valid && ready
//  results   out   value[11:0], agreed, result_channel[7:0]  valid && ready
//  cfg       in    cfg_wr_data[11:0] (agree_range)    cfg_wr_en
//
// Cycles: one sample transfer per cycle while samples.ready is high; a result
//   follows the sample that closes the second group of a run through the group
//   queue and the three-stage divide and compare pipeline in the back end.
// Reset: asynchronous, active low; clears group accumulators, queue and pipeline
//   valids, loads agree_range with 50. No clearing pass is needed.
// Stalls: samples.ready drops only on a group-closing sample while the two-entry
//   group queue is full, which happens only when results are held back.
module touch_trimmed_mean_agree_filter #(
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int DROP_EACH_END     = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tmaf_pkg::SAMPLE_W-1:0] cfg_wr_data,
    tmaf_in_if.sink                       samples,
    tmaf_out_if.source                    results
);

    // Samples left after dropping the extremes; the divisor of each group mean.
    localparam int KEEP_RAW = SAMPLES_PER_GROUP - 2 * DROP_EACH_END;
    localparam int KEEP     = (KEEP_RAW < 1) ? 1 : KEEP_RAW;

    logic [tmaf_pkg::SAMPLE_W-1:0] agree_range_reg;

    logic                    q_push;
    logic                    q_pop;
    tmaf_pkg::group_rec_t    q_wr_rec;
    tmaf_pkg::group_rec_t    q_rd_rec;
    tmaf_pkg::queue_status_t q_status;

    // Hold the agreement range; a write takes effect at the next comparison.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agree_range_reg <= tmaf_pkg::RANGE_RESET;
        end
        else if (cfg_wr_en)
        begin
            agree_range_reg <= cfg_wr_data;
        end
    end

    // Front: accumulate each group and push its trimmed total.
    tmaf_front #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
        .DROP_EACH_END     (DROP_EACH_END)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .push     (q_push),
        .rec      (q_wr_rec)
    );

    // Queue: decouple group closing from the divide and compare pipeline.
    tmaf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_rec (q_wr_rec),
        .pop    (q_pop),
        .rd_rec (q_rd_rec),
        .status (q_status)
    );

    // Back: mean per group, hold the first, compare against the second.
    tmaf_back #(
        .KEEP (KEEP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .agree_range (agree_range_reg),
        .q_status    (q_status),
        .q_rec       (q_rd_rec),
        .pop         (q_pop),
        .results     (results)
    );

    // A group record is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("group record pushed into full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty group queue");

    // A disagreeing run always reports value zero.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.agreed) |-> (results.value == '0))
        else $error("rejected result with nonzero value");

    // A zero range can never agree.
    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && $rose(results.valid) && ($past(agree_range_reg) == '0)
         && (agree_range_reg == '0)) |-> !results.agreed)
        else $error("agreement reported with zero range");

endmodule

/* tb/tmaf_checker.sv */
// Checker for the trimmed-mean agreement filter: predicts each result and compares it.
`timescale 1ns / 100ps

module tmaf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tmaf_pkg::SAMPLE_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [tmaf_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [tmaf_pkg::CHAN_W-1:0]   in_channel,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [tmaf_pkg::SAMPLE_W-1:0] out_value,
    input  logic                          out_agreed,
    input  logic [tmaf_pkg::CHAN_W-1:0]   out_channel,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            agree_count
);

    localparam int GROUP_LEN = 5;
    localparam int TRIM_EACH = 1;
    localparam int KEEP_LEN  = GROUP_LEN - 2 * TRIM_EACH;

    typedef struct packed {
        logic [tmaf_pkg::SAMPLE_W-1:0] value;
        logic                          agreed;
        logic [tmaf_pkg::CHAN_W-1:0]   chan;
    } reading_t;

    reading_t            expected_readings[$];
    reading_t            want;
    reading_t            fresh;

    logic [tmaf_pkg::SAMPLE_W-1:0] range_now;
    logic [tmaf_pkg::TOTAL_W-1:0]  grp_sum;
    logic [tmaf_pkg::TOTAL_W-1:0]  kept;
    logic [tmaf_pkg::SAMPLE_W-1:0] grp_min;
    logic [tmaf_pkg::SAMPLE_W-1:0] grp_max;
    int                            grp_count;
    logic [tmaf_pkg::SAMPLE_W-1:0] first_mean;
    logic [tmaf_pkg::SAMPLE_W-1:0] mean;
    logic [tmaf_pkg::SAMPLE_W-1:0] spread;
    logic [tmaf_pkg::SAMPLE_W:0]   pair_sum;
    logic                          in_second;
    logic                          ok;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_now  = tmaf_pkg::RANGE_RESET;
            grp_sum    = '0;
            grp_min    = tmaf_pkg::SAMPLE_MAX;
            grp_max    = '0;
            grp_count  = 0;
            first_mean = '0;
            in_second  = 1'b0;
            expected_readings.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
            agree_count  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                range_now = cfg_wr_data;

            // Compare before pushing, so a result never meets its own sample.
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_readings.size() == 0)
                begin
                    $error("unexpected result: value %0d agreed %0b result_channel %0d",
                           out_value, out_agreed, out_channel);
                    fail_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d", want.value, out_value);
                        fail_count++;
                    end
                    if (out_agreed !== want.agreed)
                    begin
                        $error("agreed: expected %0b, actual %0b", want.agreed, out_agreed);
                        fail_count++;
                    end
                    if (out_channel !== want.chan)
                    begin
                        $error("result_channel: expected %0d, actual %0d",
                               want.chan, out_channel);
                        fail_count++;
                    end
                end
                if (out_agreed === 1'b1)
                    agree_count++;
            end

            if (in_valid && in_ready)
            begin
                grp_sum = grp_sum + tmaf_pkg::TOTAL_W'(in_sample);
                if (in_sample < grp_min)
                    grp_min = in_sample;
                if (in_sample > grp_max)
                    grp_max = in_sample;
                grp_count++;
                if (grp_count == GROUP_LEN)
                begin
                    kept = grp_sum;
                    if (TRIM_EACH != 0)
                        kept = kept - tmaf_pkg::TOTAL_W'(grp_min)
                                    - tmaf_pkg::TOTAL_W'(grp_max);
                    mean = tmaf_pkg::SAMPLE_W'(kept / KEEP_LEN);
                    grp_sum   = '0;
                    grp_min   = tmaf_pkg::SAMPLE_MAX;
                    grp_max   = '0;
                    grp_count = 0;
                    if (!in_second)
                    begin
                        first_mean = mean;
                        in_second  = 1'b1;
                    end
                    else
                    begin
                        in_second = 1'b0;
                        spread = (mean >= first_mean) ? mean - first_mean : first_mean - mean;
                        ok = spread < range_now;
                        pair_sum = {1'b0, first_mean} + {1'b0, mean};
                        fresh.value  = ok ? pair_sum[tmaf_pkg::SAMPLE_W:1] : '0;
                        fresh.agreed = ok;
                        fresh.chan   = in_channel;
                        expected_readings.push_back(fresh);
                    end
                end
            end

            pending = expected_readings.size();
        end
    end

endmodule

/* tb/tb_touch_trimmed_mean_agree_filter.sv */
// Testbench top for the trimmed-mean agreement filter: stimulus, result sink and verdict.
`timescale 1ns / 100ps

module tb_touch_trimmed_mean_agree_filter;

    localparam int PHASE_ITEMS     = 255;
    localparam int DRAIN_CYCLES    = 8;    // lets the pipeline empty before a range write
    localparam int TAIL_CYCLES     = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TIMEOUT_NS      = 400_000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [tmaf_pkg::SAMPLE_W-1:0] cfg_wr_data;

    // Idling switches for the sender (src_idle) and the result sink (sink_idle, hold_off_req).
    logic src_idle;
    logic sink_idle;
    logic hold_off_req;

    int sent_count;
    int cfg_writes;
    int fail_count;
    int pending;
    int result_count;
    int agree_count;

    tmaf_in_if  samples_ch();
    tmaf_out_if results_ch();

    touch_trimmed_mean_agree_filter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples_ch),
        .results     (results_ch)
    );

    tmaf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (samples_ch.valid),
        .in_ready     (samples_ch.ready),
        .in_sample    (samples_ch.sample),
        .in_channel   (samples_ch.channel),
        .out_valid    (results_ch.valid),
        .out_ready    (results_ch.ready),
        .out_value    (results_ch.value),
        .out_agreed   (results_ch.agreed),
        .out_channel  (results_ch.result_channel),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .agree_count  (agree_count)
    );

    always #1 clk = ~clk;

    // Offer one sample and hold it until the transfer; return at the next falling edge.
    // An optional idle burst comes first, with valid dropped for its whole length.
    task automatic send_sample(input logic [tmaf_pkg::SAMPLE_W-1:0] s,
                               input logic [tmaf_pkg::CHAN_W-1:0] c);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.sample  <= s;
        samples_ch.channel <= c;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // Wait until every expected result has come and the pipeline has emptied,
    // then write agree_range. A partial run may still be held in the block.
    task automatic settle_and_set_range(input logic [tmaf_pkg::SAMPLE_W-1:0] v);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // Touch-like readings: a resting level with noise around it, the pen moving
    // now and then, and an occasional glitch sample anywhere on the scale.
    task automatic drive_readings(input int count, input int spread);
        int base;
        int v;
        int k;
        logic [tmaf_pkg::CHAN_W-1:0] chan;
        base = $urandom_range(0, 4095);
        chan = tmaf_pkg::CHAN_W'($urandom_range(0, 255));
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                if ($urandom_range(0, 5) == 0)
                    base = 4095 * $urandom_range(0, 1);
                else
                    base = $urandom_range(0, 4095);
                chan = tmaf_pkg::CHAN_W'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 4095);
            else
            begin
                v = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
            if ($urandom_range(0, 7) == 0)
                send_sample(tmaf_pkg::SAMPLE_W'(v),
                            tmaf_pkg::CHAN_W'($urandom_range(0, 255)));
            else
                send_sample(tmaf_pkg::SAMPLE_W'(v), chan);
        end
    endtask

    // Result sink: random stall bursts, one long hold-off on request.
    // After reset, ready is assigned only at falling edges, once at the start of each stall burst or hold-off.
    initial
    begin : result_sink
        int n;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                results_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 17);
                results_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // Drop the run if it hangs.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        logic [tmaf_pkg::SAMPLE_W-1:0] ranges [6];
        int spreads [6];

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        samples_ch.valid   = 1'b0;
        samples_ch.sample  = '0;
        samples_ch.channel = '0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        hold_off_req = 1'b0;
        sent_count   = 0;
        cfg_writes   = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed run at the reset range of 50: a first group of full-scale
        // extremes, a second group close to its mean, channels mixed throughout.
        // Trimmed means 1365 and 1365, so they agree; the last channel travels.
        send_sample(12'd0,    8'd0);
        send_sample(12'd4095, 8'd255);
        send_sample(12'd0,    8'hAA);
        send_sample(12'd4095, 8'h55);
        send_sample(12'd0,    8'd255);
        send_sample(12'd1365, 8'd0);
        send_sample(12'd1366, 8'h0F);
        send_sample(12'd1364, 8'hF0);
        send_sample(12'd1300, 8'd255);
        send_sample(12'd1400, 8'h5A);

        // Second directed run: identical full-scale groups, with the range
        // dropped to zero between them. Zero never accepts, and the write
        // must land on the comparison of this run, keeping the first group.
        for (k = 0; k < 5; k++)
            send_sample(12'd4095, 8'd255);
        samples_ch.valid <= 1'b0;
        settle_and_set_range('0);
        for (k = 0; k < 5; k++)
            send_sample(12'd4095, 8'(k));

        // Random phases, each at its own range; extremes 4095, 1 and 0 included.
        ranges[0] = tmaf_pkg::SAMPLE_MAX;                        spreads[0] = 400;
        ranges[1] = 12'd1;                                       spreads[1] = 1;
        ranges[2] = tmaf_pkg::SAMPLE_W'($urandom_range(2, 120)); spreads[2] = 30;
        ranges[3] = '0;                                          spreads[3] = 10;
        ranges[4] = tmaf_pkg::SAMPLE_W'($urandom_range(0, 4095)); spreads[4] = 300;
        ranges[5] = tmaf_pkg::SAMPLE_W'($urandom_range(20, 400)); spreads[5] = 60;

        for (k = 0; k < 6; k++)
        begin
            // Lower valid before the write; the phase may end mid-run.
            samples_ch.valid <= 1'b0;
            settle_and_set_range(ranges[k]);
            if (k == 1)
                hold_off_req <= 1'b1;   // back up the group queue, stall the input
            if (k == 5)
            begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            drive_readings(PHASE_ITEMS, spreads[k]);
        end
        samples_ch.valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline empty.
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Summary: %0d sample transfers, %0d results (%0d agreed), %0d range writes.",
                 sent_count, result_count, agree_count, cfg_writes);
        $display("Ranges 0, 1, 50, 4095 and random; idle bursts, a %0d-cycle result hold-off.",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
